// ===== sv/ihsf_pkg.sv =====
// Shared types and constants of the IPv4 hash set filter.
package ihsf_pkg;

   localparam int ADDR_W = 32;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_HASH  = 4'b0100,
      ST_EVAL  = 4'b1000
   } state_type;

endpackage

// ===== sv/ihsf_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface ihsf_req_if;
   import ihsf_pkg::*;
   logic              valid;
   logic              ready;
   logic              func;
   logic [ADDR_W-1:0] address;
   modport source (output valid, output func, output address, input ready);
   modport sink   (input valid, input func, input address, output ready);
endinterface

interface ihsf_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic pass;
   logic status;
   modport source (output valid, output hit, output pass, output status, input ready);
   modport sink   (input valid, input hit, input pass, input status, output ready);
endinterface

// ===== sv/ipv4_hash_set_filter_unit.sv =====
// Top level of the IPv4 hash set filter: a bucketed set of addresses.
//
// Each request inserts or looks up one address in bucket (address mod BUCKETS); a bucket
// row of WAYS addresses and its fill count are read from two RAMs in one access, compared
// or updated, and written back. One request is in work at a time and the response sits in
// an output register, so the next request is taken while it waits. With BUCKETS a power of
// two a request passes through accept, bucket index and row read; otherwise the remainder by
// reciprocal multiplication adds a product step ahead of the remainder. After reset a
// clearing pass zeroes the fill counts of all buckets, and no request is taken until it ends.
// A full bucket drops the insert with status 1; duplicates use a slot.
module ipv4_hash_set_filter_unit #(
   parameter int BUCKETS = 1024,
   parameter int WAYS    = 4
) (
   input  logic          clock,
   input  logic          reset,
   ihsf_req_if.sink      req_bus,
   ihsf_rsp_if.source    rsp_bus
);
   import ihsf_pkg::*;

   localparam int BW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
   localparam int FW = $clog2(WAYS + 1);
   localparam int RW = WAYS * ADDR_W;

   state_type         state_ff, state_in;
   logic [BW-1:0]     clr_ff, clr_in;
   logic              func_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              hit_ff, pass_ff, status_ff;

   logic              req_fire, eval_fire, idx_done;
   logic [BW-1:0]     bucket;
   logic              fill_we, row_we;
   logic [BW-1:0]     fill_waddr;
   logic [FW-1:0]     fill_rd, fill_wdata;
   logic [RW-1:0]     row_rd, row_wdata;
   logic              found, full;

   assign req_bus.ready = state_ff == ST_IDLE;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign eval_fire     = (state_ff == ST_EVAL) && (!rsp_valid_ff || rsp_bus.ready);

   ihsf_bucket #(.BUCKETS(BUCKETS), .BW(BW)) u_bucket (
      .clock   (clock),
      .reset   (reset),
      .start   (req_fire),
      .address (req_bus.address),
      .done    (idx_done),
      .index   (bucket)
   );

   ihsf_ram #(.WIDTH(FW), .DEPTH(BUCKETS)) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_waddr),
      .wr_data (fill_wdata),
      .rd_addr (bucket),
      .rd_data (fill_rd)
   );

   ihsf_ram #(.WIDTH(RW), .DEPTH(BUCKETS)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (bucket),
      .wr_data (row_wdata),
      .rd_addr (bucket),
      .rd_data (row_rd)
   );

   always_comb begin
      found     = 1'b0;
      full      = fill_rd >= FW'(WAYS);
      row_wdata = row_rd;
      for (int k = 0; k < WAYS; k++) begin
         if (FW'(k) < fill_rd && row_rd[k*ADDR_W +: ADDR_W] == addr_ff) begin
            found = 1'b1;
         end
         if (FW'(k) == fill_rd) begin
            row_wdata[k*ADDR_W +: ADDR_W] = addr_ff;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      fill_we      = 1'b0;
      fill_waddr   = bucket;
      fill_wdata   = fill_rd + 1'b1;
      row_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      case (state_ff)
         ST_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            fill_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == BW'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (idx_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (eval_fire) begin
               fill_we      = (func_ff == FUNC_INSERT) && !full;
               row_we       = (func_ff == FUNC_INSERT) && !full;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         func_ff <= req_bus.func;
         addr_ff <= req_bus.address;
      end
      if (eval_fire) begin
         if (func_ff == FUNC_INSERT) begin
            hit_ff    <= 1'b0;
            pass_ff   <= 1'b1;
            status_ff <= full ? STATUS_FULL : STATUS_OK;
         end else begin
            hit_ff    <= found;
            pass_ff   <= !found;
            status_ff <= STATUS_OK;
         end
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.hit    = hit_ff;
   assign rsp_bus.pass   = pass_ff;
   assign rsp_bus.status = status_ff;
endmodule

// ===== sv/ihsf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ihsf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/ihsf_bucket.sv =====
// Bucket index unit: address modulo the bucket count.
module ihsf_bucket #(
   parameter int BUCKETS = 1024,
   parameter int BW      = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ihsf_pkg::ADDR_W-1:0]  address,
   output logic                         done,
   output logic [BW-1:0]                index
);
   import ihsf_pkg::*;

   localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

   generate
      if (IS_POW2) begin : g_mask
         logic [BW-1:0] idx_ff;
         logic          done_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               idx_ff <= address[BW-1:0] & BW'(BUCKETS - 1);
            end
         end

         assign done  = done_ff;
         assign index = idx_ff;
      end else begin : g_recip
         localparam int SH = $clog2(BUCKETS);
         localparam logic [63:0] M_FULL =
            ((64'd1 << (ADDR_W + SH)) / 64'(BUCKETS)) + 64'd1;
         localparam logic [ADDR_W-1:0] M_LO = M_FULL[ADDR_W-1:0];
         localparam logic              M_HI = M_FULL[ADDR_W];

         logic [ADDR_W-1:0]   addr_ff;
         logic [2*ADDR_W:0]   prod_ff, prod_in;
         logic [ADDR_W-1:0]   quot;
         logic [BW-1:0]       rem_ff, rem_in;
         logic                stage_ff, done_ff;

         always_comb begin
            prod_in = {1'b0, (2*ADDR_W)'(address) * (2*ADDR_W)'(M_LO)};
            if (M_HI) begin
               prod_in = prod_in + {1'b0, address, ADDR_W'(0)};
            end
            quot   = ADDR_W'(prod_ff >> (ADDR_W + SH));
            rem_in = BW'(addr_ff - quot * ADDR_W'(BUCKETS));
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               stage_ff <= 1'b0;
               done_ff  <= 1'b0;
            end else begin
               stage_ff <= start;
               done_ff  <= stage_ff;
            end
            if (start) begin
               addr_ff <= address;
               prod_ff <= prod_in;
            end
            if (stage_ff) begin
               rem_ff <= rem_in;
            end
         end

         assign done  = done_ff;
         assign index = rem_ff;
      end
   endgenerate
endmodule

// ===== sv/ihsf_checker.sv =====
// Port-level checker for the IPv4 hash set filter, bound to the top level.
module ihsf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit,
   input logic rsp_pass,
   input logic rsp_status
);
   logic [1:0] open_ff, open_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      open_in = open_ff;
      if (req_fire && !rsp_fire) begin
         open_in = open_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("response without an open request");

   a_two_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> open_ff != 2'd2)
      else $error("request taken with two already open");

   a_flags_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pass != rsp_hit) && (!rsp_status || rsp_pass))
      else $error("inconsistent hit, pass and status");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_status))
      else $error("stalled response dropped or changed");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");
endmodule

bind ipv4_hash_set_filter_unit ihsf_checker u_ihsf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_hit    (rsp_bus.hit),
   .rsp_pass   (rsp_bus.pass),
   .rsp_status (rsp_bus.status)
);

// ===== tb/tb_ipv4_hash_set_filter_unit.sv =====
// Self-checking testbench of the IPv4 hash set filter: directed table, then random requests.
module tb_ipv4_hash_set_filter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ihsf_pkg::*;

   localparam int unsigned BUCKETS        = 1024;
   localparam int unsigned WAYS           = 4;
   localparam int unsigned HOT_COUNT      = 8;
   localparam int unsigned RANDOM_ITEMS   = 850;
   localparam int unsigned DRAIN_CYCLES   = 40;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned ROW_COUNT      = 24;

   typedef struct packed {
      logic hit;
      logic pass;
      logic status;
   } filter_rsp_type;

   typedef struct {
      bit             typed;
      filter_rsp_type rsp;
   } row_note_type;

   typedef struct {
      logic              func;
      logic [ADDR_W-1:0] address;
      bit                typed;
      filter_rsp_type    rsp;
   } probe_row_type;

   localparam filter_rsp_type RSP_MISS    = '{1'b0, 1'b1, STATUS_OK};
   localparam filter_rsp_type RSP_HIT     = '{1'b1, 1'b0, STATUS_OK};
   localparam filter_rsp_type RSP_STORED  = '{1'b0, 1'b1, STATUS_OK};
   localparam filter_rsp_type RSP_DROPPED = '{1'b0, 1'b1, STATUS_FULL};

   logic clock;
   logic reset;
   bit   steady = 1'b0;

   ihsf_req_if req_bus();
   ihsf_rsp_if rsp_bus();

   ipv4_hash_set_filter_unit #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   int unsigned       fill_count [BUCKETS];
   logic [ADDR_W-1:0] slot_address [BUCKETS*WAYS];
   filter_rsp_type    pending_verdicts [$];
   row_note_type      row_notes [$];
   logic [ADDR_W-1:0] listed_addresses [$];
   int unsigned       busy_buckets [HOT_COUNT];
   int unsigned       mismatch_count = 0;
   int unsigned       idle_cycles = 0;
   probe_row_type     probe_rows [ROW_COUNT];

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic filter_rsp_type lookup_or_insert(input logic f,
                                                       input logic [ADDR_W-1:0] a);
      int unsigned    b;
      int unsigned    n;
      filter_rsp_type r;
      b = a % BUCKETS;
      n = fill_count[b];
      r = RSP_MISS;
      if (f == FUNC_INSERT) begin
         if (n >= WAYS) begin
            r.status = STATUS_FULL;
         end else begin
            slot_address[b*WAYS + n] = a;
            fill_count[b] = n + 1;
         end
      end else begin
         for (int k = 0; k < n; k++) begin
            if (slot_address[b*WAYS + k] == a) begin
               r.hit  = 1'b1;
               r.pass = 1'b0;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("ERROR %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic got, input logic want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %b, want %b", name, got, want));
      end
   endtask

   task automatic send_request(input logic f, input logic [ADDR_W-1:0] a, input bit typed,
                               input filter_rsp_type rsp);
      row_notes.insert(row_notes.size(), '{typed, rsp});
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 27) begin
         req_bus.valid   <= 1'b0;
         req_bus.func    <= 1'($urandom());
         req_bus.address <= $urandom();
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.func    <= f;
      req_bus.address <= a;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 27);
   end

   always @(posedge clock) begin
      filter_rsp_type due;
      filter_rsp_type model;
      row_note_type   note;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               due = pending_verdicts.pop_front();
               check_field("hit", rsp_bus.hit, due.hit);
               check_field("pass", rsp_bus.pass, due.pass);
               check_field("status", rsp_bus.status, due.status);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            model = lookup_or_insert(req_bus.func, req_bus.address);
            note  = '{1'b0, RSP_MISS};
            if (row_notes.size() != 0) note = row_notes.pop_front();
            pending_verdicts.insert(pending_verdicts.size(), note.typed ? note.rsp : model);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned       pick;
      logic              f;
      logic [ADDR_W-1:0] a;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.func    = FUNC_LOOKUP;
      req_bus.address = '0;
      rsp_bus.ready   = 1'b0;
      foreach (fill_count[b]) fill_count[b] = 0;
      probe_rows = '{
         '{FUNC_LOOKUP, 32'h0000_0000, 1'b1, RSP_MISS},
         '{FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b1, RSP_MISS},
         '{FUNC_INSERT, 32'h0000_0000, 1'b1, RSP_STORED},
         '{FUNC_LOOKUP, 32'h0000_0000, 1'b1, RSP_HIT},
         '{FUNC_INSERT, 32'h0000_0400, 1'b1, RSP_STORED},
         '{FUNC_INSERT, 32'h0000_0800, 1'b1, RSP_STORED},
         '{FUNC_INSERT, 32'h0000_0000, 1'b1, RSP_STORED},
         '{FUNC_INSERT, 32'h0000_0C00, 1'b1, RSP_DROPPED},
         '{FUNC_LOOKUP, 32'h0000_0C00, 1'b1, RSP_MISS},
         '{FUNC_LOOKUP, 32'h0000_0800, 1'b1, RSP_HIT},
         '{FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, RSP_STORED},
         '{FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, RSP_STORED},
         '{FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, RSP_STORED},
         '{FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, RSP_STORED},
         '{FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, RSP_DROPPED},
         '{FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b1, RSP_HIT},
         '{FUNC_LOOKUP, 32'h7FFF_FFFF, 1'b1, RSP_MISS},
         '{FUNC_INSERT, 32'h8000_03FF, 1'b1, RSP_DROPPED},
         '{FUNC_INSERT, 32'h1234_5678, 1'b0, RSP_MISS},
         '{FUNC_LOOKUP, 32'h1234_5678, 1'b0, RSP_MISS},
         '{FUNC_LOOKUP, 32'h1234_5278, 1'b0, RSP_MISS},
         '{FUNC_INSERT, 32'hAAAA_AAAA, 1'b0, RSP_MISS},
         '{FUNC_LOOKUP, 32'h5555_5555, 1'b0, RSP_MISS},
         '{FUNC_LOOKUP, 32'hAAAA_AAAA, 1'b0, RSP_MISS}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (probe_rows[i]) begin
         send_request(probe_rows[i].func, probe_rows[i].address, probe_rows[i].typed,
                      probe_rows[i].rsp);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) begin
            foreach (busy_buckets[h]) busy_buckets[h] = $urandom_range(0, BUCKETS - 1);
         end
         steady = (i >= 400 && i < 550);
         pick = $urandom_range(0, 99);
         a = $urandom();
         a = (a / BUCKETS) * BUCKETS + busy_buckets[$urandom_range(0, HOT_COUNT - 1)];
         f = FUNC_INSERT;
         if (pick < 35) begin
            f = FUNC_INSERT;
         end else if (pick < 45 && listed_addresses.size() != 0) begin
            a = listed_addresses[$urandom_range(0, listed_addresses.size() - 1)];
         end else if (pick < 75 && listed_addresses.size() != 0) begin
            f = FUNC_LOOKUP;
            a = listed_addresses[$urandom_range(0, listed_addresses.size() - 1)];
         end else if (pick < 90) begin
            f = FUNC_LOOKUP;
         end else begin
            f = 1'($urandom_range(0, 1));
            a = $urandom();
         end
         if (f == FUNC_INSERT) listed_addresses.insert(listed_addresses.size(), a);
         send_request(f, a, 1'b0, RSP_MISS);
      end
      steady = 1'b0;

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
